/* hdl/mfb_pkg.sv */
package mfb_pkg;

   localparam int ScreenWidth  = 128;
   localparam int ScreenHeight = 64;
   localparam int FbBytes      = ScreenWidth * ((ScreenHeight + 7) / 8);
   localparam int AddrWidth    = $clog2(FbBytes);

   typedef enum logic [2:0] {
      CMD_CLEAR  = 3'd0,
      CMD_PIXEL  = 3'd1,
      CMD_LINE   = 3'd2,
      CMD_RECT   = 3'd3,
      CMD_FILL   = 3'd4,
      CMD_CIRCLE = 3'd5,
      CMD_READ   = 3'd6,
      CMD_NONE   = 3'd7
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_SET     = 2'd0,
      MODE_CLR     = 2'd1,
      MODE_INV     = 2'd2,
      MODE_INVALID = 2'd3
   } mode_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_CLEAR,
      ST_LINE_SETUP,
      ST_LINE,
      ST_FILL,
      ST_CIRCLE,
      ST_READ,
      ST_DRAIN,
      ST_RESP
   } state_type;

endpackage

/* hdl/mono_framebuffer_line_circle_raster_top.sv */
// channel   ports                                   direction
// req_      command x0 y0 x1 y1 rect_width ...      in   valid/ready
// rsp_      status read_data                        out  valid/ready
//
// one pixel read-modify-write per cycle through the framebuffer memory port;
// a line visits max(|dx|,|dy|)+1 pixels, a circle eight octant points per step, a fill w*h,
// an outline four lines, each after a setup step, and a draw ends with a pipeline drain.
// clear sweeps all 1024 bytes, one a cycle; reset runs the same sweep first.
// a single request is worked at a time; ready is low until the response is taken.
module mono_framebuffer_line_circle_raster_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_command,
   input  logic signed [11:0] req_x0,
   input  logic signed [11:0] req_y0,
   input  logic signed [11:0] req_x1,
   input  logic signed [11:0] req_y1,
   input  logic [10:0] req_rect_width,
   input  logic [10:0] req_rect_height,
   input  logic [10:0] req_radius,
   input  logic [1:0]  req_draw_mode,
   input  logic [9:0]  req_read_address,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [7:0]  rsp_read_data
);

   localparam int AW = mfb_pkg::AddrWidth;

   mfb_pkg::state_type state_ff, state_in;

   logic [7:0]  mem [mfb_pkg::FbBytes];
   logic [7:0]  rd_data_ff;

   // command registers
   mfb_pkg::cmd_type cmd_ff;
   logic [1:0]  mode_ff;
   logic signed [13:0] px_ff, py_ff;
   logic signed [13:0] ex_ff, ey_ff;
   logic signed [13:0] dx_ff, dy_ff, err_ff;
   logic        sx_ff, sy_ff;
   logic [1:0]  seg_ff;
   logic signed [13:0] ox_ff, oy_ff, rx_ff, by_ff;
   logic signed [13:0] fx_ff, fy_ff;
   logic signed [13:0] cx_ff, cy_ff;
   logic signed [15:0] cd_ff;
   logic [2:0]  oct_ff;
   logic [AW-1:0] sweep_ff;
   logic        status_ff;
   logic [7:0]  data_ff;

   // read-modify-write pipeline: stage 1 holds the address in flight
   logic          p1_v_ff;
   logic [AW-1:0] p1_a_ff;
   logic [7:0]    p1_m_ff;
   logic          p2_v_ff;
   logic [AW-1:0] p2_a_ff;
   logic [7:0]    p2_d_ff;

   // plot request from the sequencer
   logic          pl_v;
   logic signed [13:0] pl_x, pl_y;
   logic          pl_on;
   logic [AW-1:0] pl_a;
   logic [7:0]    pl_m;

   always_comb begin
      pl_on = (pl_x >= 0) && (pl_x < 14'(mfb_pkg::ScreenWidth)) && (pl_y >= 0)
            && (pl_y < 14'(mfb_pkg::ScreenHeight));
      pl_a = AW'((pl_y >>> 3) * 14'(mfb_pkg::ScreenWidth) + pl_x);
      pl_m = 8'(1) << pl_y[2:0];
   end

   // modified byte, forwarding from the write held in stage 2
   logic [7:0] old_b, new_b;
   always_comb begin
      old_b = (p2_v_ff && p2_a_ff == p1_a_ff) ? p2_d_ff : rd_data_ff;
      case (mode_ff)
         mfb_pkg::MODE_SET: new_b = old_b | p1_m_ff;
         mfb_pkg::MODE_CLR: new_b = old_b & ~p1_m_ff;
         default:           new_b = old_b ^ p1_m_ff;
      endcase
   end

   logic          wr_en;
   logic [AW-1:0] wr_a;
   logic [7:0]    wr_d;
   logic [AW-1:0] rd_a;
   always_comb begin
      wr_en = p1_v_ff;
      wr_a  = p1_a_ff;
      wr_d  = new_b;
      rd_a  = (state_ff == mfb_pkg::ST_IDLE) ? req_read_address[AW-1:0] : pl_a;
      if (state_ff == mfb_pkg::ST_INIT || state_ff == mfb_pkg::ST_CLEAR) begin
         wr_en = 1'b1;
         wr_a  = sweep_ff;
         wr_d  = 8'h00;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_a] <= wr_d;
      rd_data_ff <= mem[rd_a];
   end

   // line step values
   logic signed [14:0] e2;
   logic line_done, step_x, step_y;
   always_comb begin
      e2 = {err_ff, 1'b0};
      line_done = (px_ff == ex_ff) && (py_ff == ey_ff);
      step_x = e2 > -15'(dy_ff);
      step_y = e2 < 15'(dx_ff);
   end

   // circle octant points
   always_comb begin
      unique case (oct_ff)
         3'd0: begin pl_x = ox_ff + cx_ff; pl_y = oy_ff + cy_ff; end
         3'd1: begin pl_x = ox_ff - cx_ff; pl_y = oy_ff + cy_ff; end
         3'd2: begin pl_x = ox_ff + cx_ff; pl_y = oy_ff - cy_ff; end
         3'd3: begin pl_x = ox_ff - cx_ff; pl_y = oy_ff - cy_ff; end
         3'd4: begin pl_x = ox_ff + cy_ff; pl_y = oy_ff + cx_ff; end
         3'd5: begin pl_x = ox_ff - cy_ff; pl_y = oy_ff + cx_ff; end
         3'd6: begin pl_x = ox_ff + cy_ff; pl_y = oy_ff - cx_ff; end
         default: begin pl_x = ox_ff - cy_ff; pl_y = oy_ff - cx_ff; end
      endcase
      pl_v = 1'b0;
      unique case (state_ff)
         mfb_pkg::ST_LINE: begin
            pl_x = px_ff; pl_y = py_ff; pl_v = 1'b1;
         end
         mfb_pkg::ST_FILL: begin
            pl_x = fx_ff; pl_y = fy_ff; pl_v = 1'b1;
         end
         mfb_pkg::ST_CIRCLE: pl_v = cx_ff <= cy_ff;
         default: begin
            pl_x = ox_ff; pl_y = oy_ff;
            pl_v = (cmd_ff == mfb_pkg::CMD_PIXEL) && (state_ff == mfb_pkg::ST_DRAIN)
                   && !status_ff && !p1_v_ff && !p2_v_ff && seg_ff == 2'd0;
         end
      endcase
   end

   logic fill_row_end, fill_end;
   always_comb begin
      fill_row_end = fx_ff == rx_ff;
      fill_end = fill_row_end && fy_ff == by_ff;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mfb_pkg::ST_INIT:
            if (sweep_ff == AW'(mfb_pkg::FbBytes - 1)) state_in = mfb_pkg::ST_IDLE;
         mfb_pkg::ST_IDLE:
            if (req_valid) begin
               unique case (mfb_pkg::cmd_type'(req_command))
                  mfb_pkg::CMD_CLEAR: state_in = mfb_pkg::ST_CLEAR;
                  mfb_pkg::CMD_READ:  state_in = mfb_pkg::ST_READ;
                  mfb_pkg::CMD_NONE:  state_in = mfb_pkg::ST_RESP;
                  default:
                     if (req_draw_mode == mfb_pkg::MODE_INVALID) state_in = mfb_pkg::ST_RESP;
                     else if (req_command == mfb_pkg::CMD_LINE
                              || req_command == mfb_pkg::CMD_RECT)
                        state_in = mfb_pkg::ST_LINE_SETUP;
                     else if (req_command == mfb_pkg::CMD_FILL)
                        state_in = (req_rect_width == '0 || req_rect_height == '0)
                                   ? mfb_pkg::ST_RESP : mfb_pkg::ST_FILL;
                     else if (req_command == mfb_pkg::CMD_CIRCLE)
                        state_in = mfb_pkg::ST_CIRCLE;
                     else state_in = mfb_pkg::ST_DRAIN;
               endcase
            end
         mfb_pkg::ST_CLEAR:
            if (sweep_ff == AW'(mfb_pkg::FbBytes - 1)) state_in = mfb_pkg::ST_RESP;
         mfb_pkg::ST_LINE_SETUP: state_in = mfb_pkg::ST_LINE;
         mfb_pkg::ST_LINE:
            if (line_done)
               state_in = (cmd_ff == mfb_pkg::CMD_RECT && seg_ff != 2'd3)
                          ? mfb_pkg::ST_LINE_SETUP : mfb_pkg::ST_DRAIN;
         mfb_pkg::ST_FILL: if (fill_end) state_in = mfb_pkg::ST_DRAIN;
         mfb_pkg::ST_CIRCLE: if (cx_ff > cy_ff) state_in = mfb_pkg::ST_DRAIN;
         mfb_pkg::ST_READ: state_in = mfb_pkg::ST_RESP;
         mfb_pkg::ST_DRAIN:
            if (!p1_v_ff && !pl_v) state_in = mfb_pkg::ST_RESP;
         mfb_pkg::ST_RESP: if (rsp_ready) state_in = mfb_pkg::ST_IDLE;
         default: state_in = mfb_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready     = state_ff == mfb_pkg::ST_IDLE;
      rsp_valid     = state_ff == mfb_pkg::ST_RESP;
      rsp_status    = status_ff;
      rsp_read_data = data_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mfb_pkg::ST_INIT;
         sweep_ff <= '0;
         p1_v_ff  <= 1'b0;
         p2_v_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         p1_v_ff  <= pl_v && pl_on;
         p2_v_ff  <= p1_v_ff;
         if (state_ff == mfb_pkg::ST_INIT || state_ff == mfb_pkg::ST_CLEAR)
            sweep_ff <= sweep_ff + AW'(1);
         else sweep_ff <= '0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      p1_a_ff <= pl_a;
      p1_m_ff <= pl_m;
      p2_a_ff <= p1_a_ff;
      p2_d_ff <= new_b;
      unique case (state_ff)
         mfb_pkg::ST_IDLE: begin
            cmd_ff    <= mfb_pkg::cmd_type'(req_command);
            mode_ff   <= req_draw_mode;
            seg_ff    <= 2'd0;
            data_ff   <= 8'h00;
            ox_ff     <= 14'(req_x0);
            oy_ff     <= 14'(req_y0);
            rx_ff     <= 14'(req_x0) + 14'(req_rect_width) - 14'sd1;
            by_ff     <= 14'(req_y0) + 14'(req_rect_height) - 14'sd1;
            fx_ff     <= 14'(req_x0);
            fy_ff     <= 14'(req_y0);
            cx_ff     <= '0;
            cy_ff     <= 14'(req_radius);
            cd_ff     <= 16'sd3 - {4'd0, req_radius, 1'b0};
            oct_ff    <= '0;
            if (req_command == mfb_pkg::CMD_RECT) begin
               px_ff <= 14'(req_x0); py_ff <= 14'(req_y0);
               ex_ff <= 14'(req_x0) + 14'(req_rect_width) - 14'sd1;
               ey_ff <= 14'(req_y0);
            end else begin
               px_ff <= 14'(req_x0); py_ff <= 14'(req_y0);
               ex_ff <= 14'(req_x1); ey_ff <= 14'(req_y1);
            end
            unique case (mfb_pkg::cmd_type'(req_command))
               mfb_pkg::CMD_CLEAR: status_ff <= 1'b0;
               mfb_pkg::CMD_READ:
                  status_ff <= 32'(req_read_address) >= 32'(mfb_pkg::FbBytes);
               mfb_pkg::CMD_NONE: status_ff <= 1'b1;
               mfb_pkg::CMD_PIXEL:
                  status_ff <= (req_draw_mode == mfb_pkg::MODE_INVALID)
                     || req_x0 < 0 || req_y0 < 0
                     || 14'(req_x0) >= 14'(mfb_pkg::ScreenWidth)
                     || 14'(req_y0) >= 14'(mfb_pkg::ScreenHeight);
               default: status_ff <= req_draw_mode == mfb_pkg::MODE_INVALID;
            endcase
         end
         mfb_pkg::ST_READ:
            if (!status_ff) data_ff <= rd_data_ff;
         mfb_pkg::ST_LINE_SETUP: begin
            dx_ff  <= (ex_ff > px_ff) ? ex_ff - px_ff : px_ff - ex_ff;
            dy_ff  <= (ey_ff > py_ff) ? ey_ff - py_ff : py_ff - ey_ff;
            sx_ff  <= px_ff < ex_ff;
            sy_ff  <= py_ff < ey_ff;
            err_ff <= ((ex_ff > px_ff) ? ex_ff - px_ff : px_ff - ex_ff)
                    - ((ey_ff > py_ff) ? ey_ff - py_ff : py_ff - ey_ff);
         end
         mfb_pkg::ST_LINE:
            if (line_done) begin
               seg_ff <= seg_ff + 2'd1;
               unique case (seg_ff)
                  2'd0: begin px_ff <= rx_ff; py_ff <= oy_ff; ex_ff <= rx_ff; ey_ff <= by_ff; end
                  2'd1: begin px_ff <= rx_ff; py_ff <= by_ff; ex_ff <= ox_ff; ey_ff <= by_ff; end
                  2'd2: begin px_ff <= ox_ff; py_ff <= by_ff; ex_ff <= ox_ff; ey_ff <= oy_ff; end
                  default: ;
               endcase
            end else begin
               err_ff <= err_ff - (step_x ? dy_ff : 14'sd0) + (step_y ? dx_ff : 14'sd0);
               if (step_x) px_ff <= sx_ff ? px_ff + 14'sd1 : px_ff - 14'sd1;
               if (step_y) py_ff <= sy_ff ? py_ff + 14'sd1 : py_ff - 14'sd1;
            end
         mfb_pkg::ST_FILL:
            if (fill_row_end) begin
               fx_ff <= ox_ff;
               fy_ff <= fy_ff + 14'sd1;
            end else fx_ff <= fx_ff + 14'sd1;
         mfb_pkg::ST_CIRCLE: begin
            oct_ff <= oct_ff + 3'd1;
            if (oct_ff == 3'd7) begin
               if (cd_ff < 0) cd_ff <= cd_ff + 16'({cx_ff, 2'b00}) + 16'sd6;
               else begin
                  cd_ff <= cd_ff + 16'({cx_ff - cy_ff, 2'b00}) + 16'sd10;
                  cy_ff <= cy_ff - 14'sd1;
               end
               cx_ff <= cx_ff + 14'sd1;
            end
         end
         mfb_pkg::ST_DRAIN:
            if (pl_v) seg_ff <= 2'd1;
         default: ;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_read_data))
      else $error("response changed while stalled");
   assert property (@(posedge clock) disable iff (reset)
      req_ready |-> !p1_v_ff && !p2_v_ff)
      else $error("memory write pending while idle");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while response pending");
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status |-> rsp_read_data == 8'h00)
      else $error("read data on failed request");

endmodule

/* verif/tb_mono_framebuffer_line_circle_raster_top.sv */
`timescale 1ns / 100ps

module tb_mono_framebuffer_line_circle_raster_top;

   typedef struct packed {
      logic       status;
      logic [7:0] read_data;
   } raster_rsp_type;

   localparam int CycleLimit = 4000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [2:0]         req_command = mfb_pkg::CMD_CLEAR;
   logic signed [11:0] req_x0 = '0;
   logic signed [11:0] req_y0 = '0;
   logic signed [11:0] req_x1 = '0;
   logic signed [11:0] req_y1 = '0;
   logic [10:0]        req_rect_width = '0;
   logic [10:0]        req_rect_height = '0;
   logic [10:0]        req_radius = '0;
   logic [1:0]         req_draw_mode = mfb_pkg::MODE_SET;
   logic [9:0]         req_read_address = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic               rsp_status;
   logic [7:0]         rsp_read_data;

   logic [7:0]     fb_shadow [mfb_pkg::FbBytes] = '{default: 8'h00};
   raster_rsp_type pending_rsp [$];
   int             mismatch_count = 0;
   int             request_count = 0;
   int             response_count = 0;
   int             cycle_count = 0;
   int             hold_off_cycles = 0;
   bit             sender_quiet = 1'b0;
   bit             receiver_quiet = 1'b0;

   mono_framebuffer_line_circle_raster_top i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_command(req_command),
      .req_x0(req_x0),
      .req_y0(req_y0),
      .req_x1(req_x1),
      .req_y1(req_y1),
      .req_rect_width(req_rect_width),
      .req_rect_height(req_rect_height),
      .req_radius(req_radius),
      .req_draw_mode(req_draw_mode),
      .req_read_address(req_read_address),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_status(rsp_status),
      .rsp_read_data(rsp_read_data)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CycleLimit) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("end of test: mismatches");
         $finish;
      end
   end

   // receiver: random stalls, long hold-off on demand
   always @(posedge clock) begin
      if (hold_off_cycles > 0) begin
         rsp_ready <= 1'b0;
         hold_off_cycles <= hold_off_cycles - 1;
      end else begin
         rsp_ready <= receiver_quiet || ($urandom_range(99) >= 22);
      end
   end

   // response checker
   always @(posedge clock) begin
      raster_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         response_count <= response_count + 1;
         if (pending_rsp.size() == 0) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
               $display("unexpected response status=%0d data=%02h", rsp_status,
                        rsp_read_data);
         end else begin
            want = pending_rsp.pop_front();
            if (rsp_status !== want.status || rsp_read_data !== want.read_data) begin
               mismatch_count = mismatch_count + 1;
               if (mismatch_count <= 10)
                  $display("response %0d: status exp %0d got %0d, data exp %02h got %02h",
                           response_count, want.status, rsp_status, want.read_data,
                           rsp_read_data);
            end
         end
      end
   end

   function automatic void shadow_plot(int x, int y, mfb_pkg::mode_type m);
      int idx;
      if (x < 0 || x >= mfb_pkg::ScreenWidth || y < 0 || y >= mfb_pkg::ScreenHeight) return;
      idx = (y / 8) * mfb_pkg::ScreenWidth + x;
      if (idx >= mfb_pkg::FbBytes) return;
      case (m)
         mfb_pkg::MODE_SET: fb_shadow[idx] = fb_shadow[idx] | (8'd1 << (y % 8));
         mfb_pkg::MODE_CLR: fb_shadow[idx] = fb_shadow[idx] & ~(8'd1 << (y % 8));
         mfb_pkg::MODE_INV: fb_shadow[idx] = fb_shadow[idx] ^ (8'd1 << (y % 8));
         default: ;
      endcase
   endfunction

   function automatic void shadow_line(int xa, int ya, int xb, int yb,
                                       mfb_pkg::mode_type m);
      int dx, dy, sx, sy, err, e2;
      dx = (xb > xa) ? xb - xa : xa - xb;
      dy = (yb > ya) ? yb - ya : ya - yb;
      sx = (xa < xb) ? 1 : -1;
      sy = (ya < yb) ? 1 : -1;
      err = dx - dy;
      forever begin
         shadow_plot(xa, ya, m);
         if (xa == xb && ya == yb) break;
         e2 = 2 * err;
         if (e2 > -dy) begin
            err -= dy;
            xa += sx;
         end
         if (e2 < dx) begin
            err += dx;
            ya += sy;
         end
      end
   endfunction

   function automatic void shadow_circle(int cx, int cy, int r, mfb_pkg::mode_type m);
      int x, y, d;
      x = 0;
      y = r;
      d = 3 - 2 * r;
      while (x <= y) begin
         shadow_plot(cx + x, cy + y, m);
         shadow_plot(cx - x, cy + y, m);
         shadow_plot(cx + x, cy - y, m);
         shadow_plot(cx - x, cy - y, m);
         shadow_plot(cx + y, cy + x, m);
         shadow_plot(cx - y, cy + x, m);
         shadow_plot(cx + y, cy - x, m);
         shadow_plot(cx - y, cy - x, m);
         if (d < 0) begin
            d = d + 4 * x + 6;
         end else begin
            d = d + 4 * (x - y) + 10;
            y--;
         end
         x++;
      end
   endfunction

   // runs one request against the shadow framebuffer
   function automatic raster_rsp_type raster_outcome(mfb_pkg::cmd_type c, int x0, int y0,
                                                     int x1, int y1, int w, int h, int r,
                                                     mfb_pkg::mode_type m, int addr);
      raster_rsp_type res;
      int xr, yb;
      res = '0;
      if (c == mfb_pkg::CMD_CLEAR) begin
         foreach (fb_shadow[i]) fb_shadow[i] = 8'h00;
      end else if (c == mfb_pkg::CMD_READ) begin
         if (addr < mfb_pkg::FbBytes) res.read_data = fb_shadow[addr];
         else res.status = 1'b1;
      end else if (c == mfb_pkg::CMD_NONE || m == mfb_pkg::MODE_INVALID) begin
         res.status = 1'b1;
      end else if (c == mfb_pkg::CMD_PIXEL) begin
         if (x0 >= 0 && x0 < mfb_pkg::ScreenWidth && y0 >= 0 && y0 < mfb_pkg::ScreenHeight)
            shadow_plot(x0, y0, m);
         else
            res.status = 1'b1;
      end else if (c == mfb_pkg::CMD_LINE) begin
         shadow_line(x0, y0, x1, y1, m);
      end else if (c == mfb_pkg::CMD_RECT) begin
         xr = x0 + w - 1;
         yb = y0 + h - 1;
         shadow_line(x0, y0, xr, y0, m);
         shadow_line(xr, y0, xr, yb, m);
         shadow_line(xr, yb, x0, yb, m);
         shadow_line(x0, yb, x0, y0, m);
      end else if (c == mfb_pkg::CMD_FILL) begin
         for (int yy = y0; yy < y0 + h; yy++)
            for (int xx = x0; xx < x0 + w; xx++)
               shadow_plot(xx, yy, m);
      end else begin
         shadow_circle(x0, y0, r, m);
      end
      return res;
   endfunction

   task automatic send_request(mfb_pkg::cmd_type c, logic signed [11:0] x0,
                               logic signed [11:0] y0, logic signed [11:0] x1,
                               logic signed [11:0] y1, logic [10:0] w, logic [10:0] h,
                               logic [10:0] r, mfb_pkg::mode_type m, logic [9:0] addr);
      req_valid        <= 1'b1;
      req_command      <= c;
      req_x0           <= x0;
      req_y0           <= y0;
      req_x1           <= x1;
      req_y1           <= y1;
      req_rect_width   <= w;
      req_rect_height  <= h;
      req_radius       <= r;
      req_draw_mode    <= m;
      req_read_address <= addr;
      do @(posedge clock); while (!req_ready);
      pending_rsp.push_back(raster_outcome(c, x0, y0, x1, y1, w, h, r, m, addr));
      request_count++;
      if (!sender_quiet && $urandom_range(99) < 22) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
   endtask

   task automatic read_byte(int addr);
      send_request(mfb_pkg::CMD_READ, 12'($urandom), 12'($urandom), 12'($urandom),
                   12'($urandom), 11'($urandom), 11'($urandom), 11'($urandom),
                   mfb_pkg::mode_type'($urandom_range(3)), 10'(addr));
   endtask

   task automatic read_region();
      repeat (6) read_byte($urandom_range(mfb_pkg::FbBytes - 1));
   endtask

   task automatic test_reset_state();
      read_byte(0);
      read_byte(mfb_pkg::FbBytes - 1);
      read_byte($urandom_range(mfb_pkg::FbBytes - 1));
   endtask

   task automatic test_directed();
      send_request(mfb_pkg::CMD_PIXEL, 0, 0, 0, 0, 0, 0, 0, mfb_pkg::MODE_SET, 0);
      send_request(mfb_pkg::CMD_PIXEL, 12'(mfb_pkg::ScreenWidth - 1),
                   12'(mfb_pkg::ScreenHeight - 1), 0, 0, 0, 0, 0, mfb_pkg::MODE_SET, 0);
      send_request(mfb_pkg::CMD_PIXEL, -2048, 2047, 0, 0, 0, 0, 0, mfb_pkg::MODE_SET, 0);
      send_request(mfb_pkg::CMD_PIXEL, 2047, -2048, 0, 0, 0, 0, 0, mfb_pkg::MODE_INV, 0);
      send_request(mfb_pkg::CMD_PIXEL, 3, 3, 0, 0, 0, 0, 0, mfb_pkg::MODE_INVALID, 0);
      send_request(mfb_pkg::CMD_NONE, 3, 3, 0, 0, 0, 0, 0, mfb_pkg::MODE_SET, 0);
      send_request(mfb_pkg::CMD_LINE, -2048, -2048, 2047, 2047, 0, 0, 0,
                   mfb_pkg::MODE_SET, 0);
      send_request(mfb_pkg::CMD_LINE, 127, 0, 0, 63, 0, 0, 0, mfb_pkg::MODE_INV, 0);
      send_request(mfb_pkg::CMD_RECT, 10, 10, 0, 0, 0, 0, 0, mfb_pkg::MODE_INV, 0);
      send_request(mfb_pkg::CMD_RECT, 5, 5, 0, 0, 20, 12, 0, mfb_pkg::MODE_INV, 0);
      send_request(mfb_pkg::CMD_FILL, 40, 20, 0, 0, 0, 9, 0, mfb_pkg::MODE_SET, 0);
      send_request(mfb_pkg::CMD_FILL, -1000, 30, 0, 0, 2047, 1, 0, mfb_pkg::MODE_SET, 0);
      send_request(mfb_pkg::CMD_FILL, 60, -1000, 0, 0, 1, 2047, 0, mfb_pkg::MODE_INV, 0);
      send_request(mfb_pkg::CMD_CIRCLE, 64, 32, 0, 0, 0, 0, 0, mfb_pkg::MODE_INV, 0);
      send_request(mfb_pkg::CMD_CIRCLE, 64, 32, 0, 0, 0, 0, 2047, mfb_pkg::MODE_SET, 0);
      send_request(mfb_pkg::CMD_CIRCLE, 30, 30, 0, 0, 0, 0, 20, mfb_pkg::MODE_CLR, 0);
      send_request(mfb_pkg::CMD_CIRCLE, 30, 30, 0, 0, 0, 0, 20, mfb_pkg::MODE_INVALID, 0);
      read_region();
      read_byte(0);
      read_byte(mfb_pkg::FbBytes - 1);
      send_request(mfb_pkg::CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, mfb_pkg::MODE_INVALID, 0);
      read_byte(4 * mfb_pkg::ScreenWidth);
   endtask

   task automatic random_request();
      mfb_pkg::cmd_type  c;
      mfb_pkg::mode_type m;
      logic signed [11:0] x0, y0, x1, y1;
      logic [10:0] w, h, r;
      int pick;
      pick = $urandom_range(99);
      if (pick < 3) c = mfb_pkg::CMD_CLEAR;
      else if (pick < 18) c = mfb_pkg::CMD_PIXEL;
      else if (pick < 33) c = mfb_pkg::CMD_LINE;
      else if (pick < 43) c = mfb_pkg::CMD_RECT;
      else if (pick < 53) c = mfb_pkg::CMD_FILL;
      else if (pick < 63) c = mfb_pkg::CMD_CIRCLE;
      else if (pick < 97) c = mfb_pkg::CMD_READ;
      else c = mfb_pkg::CMD_NONE;
      m = ($urandom_range(99) < 8) ? mfb_pkg::MODE_INVALID
                                   : mfb_pkg::mode_type'($urandom_range(2));
      x0 = 12'($urandom); y0 = 12'($urandom); x1 = 12'($urandom); y1 = 12'($urandom);
      w = 11'($urandom); h = 11'($urandom); r = 11'($urandom);
      if ($urandom_range(99) < 95) begin
         x0 = 12'($urandom_range(mfb_pkg::ScreenWidth + 40) - 20);
         y0 = 12'($urandom_range(mfb_pkg::ScreenHeight + 40) - 20);
         x1 = 12'($urandom_range(mfb_pkg::ScreenWidth + 40) - 20);
         y1 = 12'($urandom_range(mfb_pkg::ScreenHeight + 40) - 20);
         r = 11'($urandom_range(70));
         if (c == mfb_pkg::CMD_RECT) begin
            w = 11'($urandom_range(140));
            h = 11'($urandom_range(80));
         end
      end
      if (c == mfb_pkg::CMD_FILL) begin
         w = 11'($urandom_range(40));
         h = 11'($urandom_range(30));
      end
      if (c == mfb_pkg::CMD_READ && $urandom_range(1)) begin
         x0 = 12'($urandom_range(mfb_pkg::ScreenWidth - 1));
         y0 = 12'($urandom_range(mfb_pkg::ScreenHeight - 1));
      end
      send_request(c, x0, y0, x1, y1, w, h, r, m, 10'($urandom));
   endtask

   task automatic test_random(int n);
      repeat (n) random_request();
   endtask

   task automatic test_quiet_stretch();
      sender_quiet = 1'b1;
      receiver_quiet = 1'b1;
      test_random(150);
      sender_quiet = 1'b0;
      receiver_quiet = 1'b0;
   endtask

   task automatic test_back_pressure();
      hold_off_cycles = 400;
      repeat (6) random_request();
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      read_region();
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_state();
      test_directed();
      test_random(300);
      test_back_pressure();
      test_quiet_stretch();
      test_random(450);
      req_valid <= 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (2000) @(posedge clock);
      $display("covered %0d requests and %0d responses over all commands and modes,",
               request_count, response_count);
      $display("with random stalls, a quiet stretch and a long receiver hold-off");
      if (mismatch_count == 0 && pending_rsp.size() == 0) begin
         $display("end of test: clean");
      end else begin
         $display("%0d mismatches, %0d responses missing", mismatch_count,
                  pending_rsp.size());
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
